>>> hw/rtl/pipfan_pkg.sv
`default_nettype none

package pipfan_pkg;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic start;
    logic last;
  } ctrl_t;

  localparam ctrl_t CtrlIdle = '{valid: 1'b0, start: 1'b0, last: 1'b0};

endpackage

`default_nettype wire

>>> hw/rtl/pipfan_diff.sv
`default_nettype none

module pipfan_diff #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         accept_i,
  input  wire logic                         start_i,
  input  wire logic                         last_i,
  input  wire logic signed [COORD_BITS-1:0] query_x_i,
  input  wire logic signed [COORD_BITS-1:0] query_y_i,
  input  wire logic signed [COORD_BITS-1:0] corner_a_x_i,
  input  wire logic signed [COORD_BITS-1:0] corner_a_y_i,
  input  wire logic signed [COORD_BITS-1:0] corner_b_x_i,
  input  wire logic signed [COORD_BITS-1:0] corner_b_y_i,
  output pipfan_pkg::ctrl_t                 ctrl_o,
  output logic signed [COORD_BITS:0]        u0_o,
  output logic signed [COORD_BITS:0]        v0_o,
  output logic signed [COORD_BITS:0]        u1_o,
  output logic signed [COORD_BITS:0]        v1_o,
  output logic signed [COORD_BITS:0]        u2_o,
  output logic signed [COORD_BITS:0]        w_o
);
  import pipfan_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] point_x_q, point_y_q, origin_x_q, origin_y_q;
  ctrl_t ctrl_q;
  logic signed [DW-1:0] u0_q, v0_q, u1_q, v1_q, u2_q, w_q;

  // Fan state is written as the start word is taken, so the next word sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q  <= '0;
      point_y_q  <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (accept_i && start_i) begin
      point_x_q  <= query_x_i;
      point_y_q  <= query_y_i;
      origin_x_q <= corner_a_x_i;
      origin_y_q <= corner_a_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CtrlIdle;
    end else if (adv_i) begin
      ctrl_q <= '{valid: accept_i, start: start_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u0_q <= DW'(point_x_q) - DW'(origin_x_q);
      v0_q <= DW'(point_y_q) - DW'(origin_y_q);
      u1_q <= DW'(corner_a_x_i) - DW'(origin_x_q);
      v1_q <= DW'(corner_a_y_i) - DW'(origin_y_q);
      u2_q <= DW'(corner_b_x_i) - DW'(origin_x_q);
      w_q  <= DW'(corner_b_y_i) - DW'(origin_y_q);
    end
  end

  assign ctrl_o = ctrl_q;
  assign u0_o   = u0_q;
  assign v0_o   = v0_q;
  assign u1_o   = u1_q;
  assign v1_o   = v1_q;
  assign u2_o   = u2_q;
  assign w_o    = w_q;

endmodule

`default_nettype wire

>>> hw/rtl/pipfan_mul.sv
`default_nettype none

module pipfan_mul #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire pipfan_pkg::ctrl_t             ctrl_i,
  input  wire logic signed [COORD_BITS:0]    u0_i,
  input  wire logic signed [COORD_BITS:0]    v0_i,
  input  wire logic signed [COORD_BITS:0]    u1_i,
  input  wire logic signed [COORD_BITS:0]    v1_i,
  input  wire logic signed [COORD_BITS:0]    u2_i,
  input  wire logic signed [COORD_BITS:0]    w_i,
  output pipfan_pkg::ctrl_t                  ctrl_o,
  output logic signed [2*COORD_BITS+1:0]     p_wu1_o,
  output logic signed [2*COORD_BITS+1:0]     p_u2v1_o,
  output logic signed [2*COORD_BITS+1:0]     p_v0u1_o,
  output logic signed [2*COORD_BITS+1:0]     p_u0v1_o,
  output logic signed [2*COORD_BITS+1:0]     p_u0w_o,
  output logic signed [2*COORD_BITS+1:0]     p_v0u2_o
);
  import pipfan_pkg::*;

  localparam int PW = 2 * COORD_BITS + 2;

  ctrl_t ctrl_q;
  logic signed [PW-1:0] p_wu1_q, p_u2v1_q, p_v0u1_q, p_u0v1_q, p_u0w_q, p_v0u2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CtrlIdle;
    end else if (adv_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Six independent signed products, each (COORD_BITS+1) by (COORD_BITS+1) bits.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_wu1_q  <= w_i * u1_i;
      p_u2v1_q <= u2_i * v1_i;
      p_v0u1_q <= v0_i * u1_i;
      p_u0v1_q <= u0_i * v1_i;
      p_u0w_q  <= u0_i * w_i;
      p_v0u2_q <= v0_i * u2_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign p_wu1_o  = p_wu1_q;
  assign p_u2v1_o = p_u2v1_q;
  assign p_v0u1_o = p_v0u1_q;
  assign p_u0v1_o = p_u0v1_q;
  assign p_u0w_o  = p_u0w_q;
  assign p_v0u2_o = p_v0u2_q;

endmodule

`default_nettype wire

>>> hw/rtl/pipfan_cross.sv
`default_nettype none

module pipfan_cross #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire pipfan_pkg::ctrl_t             ctrl_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_wu1_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_u2v1_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_v0u1_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_u0v1_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_u0w_i,
  input  wire logic signed [2*COORD_BITS+1:0] p_v0u2_i,
  output pipfan_pkg::ctrl_t                  ctrl_o,
  output logic signed [2*COORD_BITS+3:0]     d_o,
  output logic signed [2*COORD_BITS+3:0]     nb_o,
  output logic signed [2*COORD_BITS+3:0]     na_o,
  output logic signed [2*COORD_BITS+3:0]     sum_o
);
  import pipfan_pkg::*;

  localparam int SW = 2 * COORD_BITS + 4;

  ctrl_t ctrl_c_q, ctrl_s_q;
  logic signed [SW-1:0] d_c_q, nb_c_q, na_c_q;
  logic signed [SW-1:0] d_s_q, nb_s_q, na_s_q, sum_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_c_q <= CtrlIdle;
      ctrl_s_q <= CtrlIdle;
    end else if (adv_i) begin
      ctrl_c_q <= ctrl_i;
      ctrl_s_q <= ctrl_c_q;
    end
  end

  // First stage forms the three cross products, the second adds na and nb.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_c_q   <= SW'(p_wu1_i) - SW'(p_u2v1_i);
      nb_c_q  <= SW'(p_v0u1_i) - SW'(p_u0v1_i);
      na_c_q  <= SW'(p_u0w_i) - SW'(p_v0u2_i);
      d_s_q   <= d_c_q;
      nb_s_q  <= nb_c_q;
      na_s_q  <= na_c_q;
      sum_s_q <= na_c_q + nb_c_q;
    end
  end

  assign ctrl_o = ctrl_s_q;
  assign d_o    = d_s_q;
  assign nb_o   = nb_s_q;
  assign na_o   = na_s_q;
  assign sum_o  = sum_s_q;

endmodule

`default_nettype wire

>>> hw/rtl/pipfan_decide.sv
`default_nettype none

module pipfan_decide #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire pipfan_pkg::ctrl_t              ctrl_i,
  input  wire logic signed [2*COORD_BITS+3:0] d_i,
  input  wire logic signed [2*COORD_BITS+3:0] nb_i,
  input  wire logic signed [2*COORD_BITS+3:0] na_i,
  input  wire logic signed [2*COORD_BITS+3:0] sum_i,
  output logic                                out_valid_o,
  output logic                                inside_res_o
);
  import pipfan_pkg::*;

  localparam int SW = 2 * COORD_BITS + 4;

  logic d_zero, d_neg, nb_zero, nb_neg, na_zero, na_neg;
  logic hit_pos, hit_neg, hit;
  logic parity_q, parity_d;
  logic out_valid_q, inside_q;

  assign d_zero  = (d_i == '0);
  assign d_neg   = d_i[SW-1];
  assign nb_zero = (nb_i == '0);
  assign nb_neg  = nb_i[SW-1];
  assign na_zero = (na_i == '0);
  assign na_neg  = na_i[SW-1];

  // Same test for both orientations, with every inequality flipped when d < 0.
  assign hit_pos = !nb_neg && !nb_zero && (nb_i <= d_i) && !na_neg && (sum_i <= d_i);
  assign hit_neg = nb_neg && (nb_i >= d_i) && (na_neg || na_zero) && (sum_i >= d_i);
  assign hit     = !d_zero && (d_neg ? hit_neg : hit_pos);

  always_comb begin
    parity_d = parity_q;
    if (ctrl_i.valid) begin
      if (ctrl_i.start) begin
        parity_d = 1'b0;
      end else if (hit) begin
        parity_d = !parity_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      parity_q    <= parity_d;
      out_valid_q <= ctrl_i.valid && ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inside_q <= parity_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

`default_nettype wire

>>> hw/rtl/point_in_polygon_fan_test_unit.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  --------------------------------------------
// in       sink       in_valid_i, in_stall_o  start_item_i, last_item_i, query_x/y_i,
//                                             corner_a_x/y_i, corner_b_x/y_i
// out      source     out_valid_o, out_stall_i inside_res_o
//
// One word is taken in every cycle while in_stall_o is low. The pipeline
// has five register stages: differences to the fan origin, six products,
// the three cross terms, the sum na + nb, and the result register, through
// which the last word of a polygon passes in turn before its result word appears.
// Reset clears the fan state, the parity and every valid bit at once.
// The whole pipeline holds only while a result word waits and out_stall_i
// is high; then in_stall_o is high too.
module point_in_polygon_fan_test_unit #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         start_item_i,
  input  wire logic                         last_item_i,
  input  wire logic signed [COORD_BITS-1:0] query_x_i,
  input  wire logic signed [COORD_BITS-1:0] query_y_i,
  input  wire logic signed [COORD_BITS-1:0] corner_a_x_i,
  input  wire logic signed [COORD_BITS-1:0] corner_a_y_i,
  input  wire logic signed [COORD_BITS-1:0] corner_b_x_i,
  input  wire logic signed [COORD_BITS-1:0] corner_b_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              inside_res_o
);
  import pipfan_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 4;

  // The pipeline moves unless the result register is full and blocked.
  logic adv, accept;

  ctrl_t ctrl_diff, ctrl_mul, ctrl_cross;
  logic signed [DW-1:0] u0, v0, u1, v1, u2, w;
  logic signed [PW-1:0] p_wu1, p_u2v1, p_v0u1, p_u0v1, p_u0w, p_v0u2;
  logic signed [SW-1:0] d, nb, na, sum;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // Stage one: edge and query point relative to the fan origin. The start
  // word also loads the fan state here.
  pipfan_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .accept_i     (accept),
    .start_i      (start_item_i),
    .last_i       (last_item_i),
    .query_x_i    (query_x_i),
    .query_y_i    (query_y_i),
    .corner_a_x_i (corner_a_x_i),
    .corner_a_y_i (corner_a_y_i),
    .corner_b_x_i (corner_b_x_i),
    .corner_b_y_i (corner_b_y_i),
    .ctrl_o       (ctrl_diff),
    .u0_o         (u0),
    .v0_o         (v0),
    .u1_o         (u1),
    .v1_o         (v1),
    .u2_o         (u2),
    .w_o          (w)
  );

  // Stage two: the six products of the barycentric numerators and determinant.
  pipfan_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctrl_i   (ctrl_diff),
    .u0_i     (u0),
    .v0_i     (v0),
    .u1_i     (u1),
    .v1_i     (v1),
    .u2_i     (u2),
    .w_i      (w),
    .ctrl_o   (ctrl_mul),
    .p_wu1_o  (p_wu1),
    .p_u2v1_o (p_u2v1),
    .p_v0u1_o (p_v0u1),
    .p_u0v1_o (p_u0v1),
    .p_u0w_o  (p_u0w),
    .p_v0u2_o (p_v0u2)
  );

  // Stages three and four: d, nb, na, then na + nb, all exact.
  pipfan_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctrl_i   (ctrl_mul),
    .p_wu1_i  (p_wu1),
    .p_u2v1_i (p_u2v1),
    .p_v0u1_i (p_v0u1),
    .p_u0v1_i (p_u0v1),
    .p_u0w_i  (p_u0w),
    .p_v0u2_i (p_v0u2),
    .ctrl_o   (ctrl_cross),
    .d_o      (d),
    .nb_o     (nb),
    .na_o     (na),
    .sum_o    (sum)
  );

  // Last stage: triangle hit test, parity update in word order, result register.
  pipfan_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .ctrl_i       (ctrl_cross),
    .d_i          (d),
    .nb_i         (nb),
    .na_i         (na),
    .sum_i        (sum),
    .out_valid_o  (out_valid_o),
    .inside_res_o (inside_res_o)
  );

endmodule

`default_nettype wire
